FILE: rtl/discrete_distribution_sampler_macros.svh
// Assertion macros shared by the sampler RTL.
// DDS_ASSERT checks a property on every clock edge outside reset.
// DDS_ASSERT_ANY checks a property on every clock edge, reset included.
`ifndef DISCRETE_DISTRIBUTION_SAMPLER_MACROS_SVH
`define DISCRETE_DISTRIBUTION_SAMPLER_MACROS_SVH

`ifndef SYNTH

`define DDS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define DDS_ASSERT_ANY(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DDS_ASSERT(lbl, clk, rst, prop, msg)

`define DDS_ASSERT_ANY(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/dds_pkg.sv
package dds_pkg;

   // Field widths fixed by the transaction formats.
   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 6;
   localparam int SPAN_W   = 7;
   localparam int WEIGHT_W = 16;
   localparam int FRAC_W   = 16;
   localparam int SIZE_W   = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE  = 2'd0,
      CMD_MASK   = 2'd1,
      CMD_SAMPLE = 2'd2,
      CMD_MAX    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

endpackage

FILE: rtl/dds_intf.sv
interface dds_req_if;
   import dds_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [INDEX_W-1:0]  position;
   logic [SPAN_W-1:0]   span_length;
   logic [WEIGHT_W-1:0] weight;
   logic [FRAC_W-1:0]   uniform_fraction;

   modport source (
      output valid, command, position, span_length, weight, uniform_fraction,
      input  ready
   );
   modport sink (
      input  valid, command, position, span_length, weight, uniform_fraction,
      output ready
   );
endinterface

interface dds_rsp_if;
   import dds_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] chosen_index;
   logic               empty_res;

   modport source (
      output valid, chosen_index, empty_res,
      input  ready
   );
   modport sink (
      input  valid, chosen_index, empty_res,
      output ready
   );
endinterface

interface dds_csr_if;
   import dds_pkg::*;

   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] size_in_use;

   modport source (
      output valid, size_in_use,
      input  ready
   );
   modport sink (
      input  valid, size_in_use,
      output ready
   );
endinterface

FILE: rtl/dds_ram.sv
module dds_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read returns the contents before a write in the same cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/discrete_distribution_sampler.sv
// Channel   Direction  Transaction contents
// req_ch    in         command, position, span_length, weight, uniform_fraction
// rsp_ch    out        chosen_index, empty_res
// csr_ch    in         size_in_use
//
// A request walks the table one entry per cycle, set by the single read port of the weight
// memory. The response is loaded in the finish state after the walk, and the next request
// can be taken in the idle state that follows. A sample ends early at its hit, and sample or
// max on an empty distribution skips the walk and goes straight to the finish state.
// After reset a clearing pass zeroes all ENTRIES entries, one per cycle; requests wait, size_in_use
// writes are taken. A size_in_use write in idle blocks requests while the total is summed again.
// A response waiting on rsp_ch holds the next request in its finish state.
`include "discrete_distribution_sampler_macros.svh"

module discrete_distribution_sampler #(
   parameter int ENTRIES = 64
) (
   input  logic       clock,
   input  logic       reset,
   dds_req_if.sink    req_ch,
   dds_rsp_if.source  rsp_ch,
   dds_csr_if.sink    csr_ch
);
   import dds_pkg::*;

   // Widths derived from the table depth.
   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int TOT_W  = WEIGHT_W + IDX_W;
   localparam int PROD_W = TOT_W + FRAC_W;
   localparam int RNG_W  = (CNT_W > SPAN_W + 1) ? CNT_W : SPAN_W + 1;
   localparam int SZX_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
   localparam int RESET_SIZE = (64 > ENTRIES) ? ENTRIES : 64;

   // Control state.
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    iss_ff, iss_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic                cfg_walk_ff, cfg_walk_in;
   logic [CNT_W-1:0]    size_ff, size_in;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Per-request payload.
   cmd_type             cmd_ff, cmd_in;
   logic [INDEX_W-1:0]  pos_ff, pos_in;
   logic [RNG_W-1:0]    mask_lo_ff, mask_lo_in;
   logic [RNG_W-1:0]    mask_hi_ff, mask_hi_in;
   logic [PROD_W-1:0]   rhs_ff, rhs_in;
   logic [TOT_W-1:0]    sum_ff, sum_in;
   logic [WEIGHT_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]    res_idx_ff, res_idx_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                cmp_zero_ff, cmp_zero_in;
   logic [INDEX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic                rsp_empty_ff, rsp_empty_in;

   // Weight memory ports.
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [WEIGHT_W-1:0] mem_wdata;
   logic [IDX_W-1:0]    mem_raddr;
   logic [WEIGHT_W-1:0] mem_rdata;

   // Combinational helpers.
   logic                req_fire, csr_fire, rsp_fire;
   cmd_type             req_cmd;
   logic                search_cmd;
   logic [SZX_W-1:0]    csr_ext;
   logic [CNT_W-1:0]    csr_eff;
   logic [IDX_W-1:0]    iss_idx;
   logic                issue, in_range, hit, walk_end, rsp_load, sum_walk;
   logic [WEIGHT_W-1:0] data_w;
   logic [TOT_W-1:0]    cum;
   logic [PROD_W-1:0]   lhs;

   dds_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (ENTRIES)
   ) u_weights (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Handshakes. Configuration wins over a request offered in the same cycle.
   assign req_ch.ready = (state_ff == ST_IDLE) && !csr_ch.valid;
   assign csr_ch.ready = (state_ff == ST_IDLE) || (state_ff == ST_CLEAR);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;
   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.chosen_index = rsp_idx_ff;
   assign rsp_ch.empty_res    = rsp_empty_ff;

   assign req_cmd    = cmd_type'(req_ch.command);
   assign search_cmd = (req_cmd == CMD_SAMPLE) || (req_cmd == CMD_MAX);

   // A size of zero behaves as one, and sizes past the table behave as the table.
   assign csr_ext = SZX_W'(csr_ch.size_in_use);
   always_comb begin
      if (csr_ext == '0) begin
         csr_eff = CNT_W'(1);
      end else if (csr_ext > SZX_W'(ENTRIES)) begin
         csr_eff = CNT_W'(ENTRIES);
      end else begin
         csr_eff = CNT_W'(csr_ext);
      end
   end

   // The walk issues one read per cycle at iss_ff; the data comes back in the next cycle,
   // when cmp_idx_ff names the entry and cmp_zero_ff says it was masked on the way.
   assign iss_idx  = IDX_W'(iss_ff);
   assign issue    = (state_ff == ST_WALK) && (iss_ff < size_ff);
   assign in_range = (cmd_ff == CMD_MASK) && !cfg_walk_ff
                     && (RNG_W'(iss_ff) >= mask_lo_ff) && (RNG_W'(iss_ff) < mask_hi_ff);
   assign data_w   = cmp_zero_ff ? '0 : mem_rdata;
   assign cum      = sum_ff + TOT_W'(data_w);
   // Cumulative weight scaled by the fraction range, compared against
   // fraction times total: an exact form of cum / total >= fraction.
   assign lhs      = {cum, {FRAC_W{1'b0}}};
   assign sum_walk = cfg_walk_ff || (cmd_ff == CMD_WRITE) || (cmd_ff == CMD_MASK);

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (iss_ff == CNT_W'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (csr_fire) begin
               state_in = ST_WALK;
            end else if (req_fire) begin
               // Sample and max on an empty distribution need no walk.
               state_in = (search_cmd && (total_ff == '0)) ? ST_FINISH : ST_WALK;
            end
         end
         ST_WALK: begin
            if (hit || walk_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (cfg_walk_ff || !rsp_valid_ff || rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin : datapath
      iss_in       = iss_ff;
      cmp_vld_in   = cmp_vld_ff;
      cfg_walk_in  = cfg_walk_ff;
      size_in      = size_ff;
      total_in     = total_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      mask_lo_in   = mask_lo_ff;
      mask_hi_in   = mask_hi_ff;
      rhs_in       = rhs_ff;
      sum_in       = sum_ff;
      best_in      = best_ff;
      res_idx_in   = res_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_zero_in  = cmp_zero_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_empty_in = rsp_empty_ff;
      mem_we       = 1'b0;
      mem_waddr    = iss_idx;
      mem_wdata    = '0;
      mem_raddr    = iss_idx;
      hit          = 1'b0;
      walk_end     = 1'b0;
      rsp_load     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            // Zero one entry per cycle; the total is already zero.
            mem_we = 1'b1;
            iss_in = iss_ff + CNT_W'(1);
            if (csr_fire) begin
               size_in = csr_eff;
            end
         end
         ST_IDLE: begin
            iss_in     = '0;
            sum_in     = '0;
            cmp_vld_in = 1'b0;
            if (csr_fire) begin
               // A new size means a new total: walk the table and sum it.
               size_in     = csr_eff;
               cfg_walk_in = 1'b1;
               cmd_in      = CMD_WRITE;
            end else if (req_fire) begin
               cfg_walk_in = 1'b0;
               cmd_in      = req_cmd;
               pos_in      = req_ch.position;
               mask_lo_in  = RNG_W'(req_ch.position);
               mask_hi_in  = RNG_W'(req_ch.position) + RNG_W'(req_ch.span_length);
               rhs_in      = PROD_W'(req_ch.uniform_fraction) * PROD_W'(total_ff);
               best_in     = '0;
               res_idx_in  = (req_cmd == CMD_SAMPLE) ? IDX_W'(size_ff - CNT_W'(1)) : '0;
               // The weight is stored here; the walk that follows resums the total.
               if ((req_cmd == CMD_WRITE)
                   && (RNG_W'(req_ch.position) < RNG_W'(ENTRIES))) begin
                  mem_we    = 1'b1;
                  mem_waddr = IDX_W'(req_ch.position);
                  mem_wdata = req_ch.weight;
               end
            end
         end
         ST_WALK: begin
            cmp_vld_in  = issue;
            cmp_idx_in  = iss_idx;
            cmp_zero_in = in_range;
            if (issue) begin
               iss_in = iss_ff + CNT_W'(1);
               if (in_range) begin
                  mem_we = 1'b1;
               end
            end
            if (cmp_vld_ff) begin
               sum_in = cum;
               if ((cmd_ff == CMD_SAMPLE) && (lhs >= rhs_ff)) begin
                  hit        = 1'b1;
                  res_idx_in = cmp_idx_ff;
               end
               // Strict compare keeps the first index of the largest weight.
               if ((cmd_ff == CMD_MAX) && (best_ff < data_w)) begin
                  best_in    = data_w;
                  res_idx_in = cmp_idx_ff;
               end
            end
            walk_end = !issue && !cmp_vld_ff;
            if (walk_end && sum_walk) begin
               total_in = sum_ff;
            end
         end
         ST_FINISH: begin
            if (!cfg_walk_ff && (!rsp_valid_ff || rsp_ch.ready)) begin
               rsp_load     = 1'b1;
               rsp_empty_in = (total_ff == '0);
               if ((cmd_ff == CMD_WRITE) || (cmd_ff == CMD_MASK)) begin
                  rsp_idx_in = pos_ff;
               end else if (total_ff == '0) begin
                  rsp_idx_in = '0;
               end else begin
                  rsp_idx_in = INDEX_W'(res_idx_ff);
               end
            end
         end
         default: begin
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         iss_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         cfg_walk_ff  <= 1'b0;
         size_ff      <= CNT_W'(RESET_SIZE);
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         cmp_vld_ff   <= cmp_vld_in;
         cfg_walk_ff  <= cfg_walk_in;
         size_ff      <= size_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      pos_ff       <= pos_in;
      mask_lo_ff   <= mask_lo_in;
      mask_hi_ff   <= mask_hi_in;
      rhs_ff       <= rhs_in;
      sum_ff       <= sum_in;
      best_ff      <= best_in;
      res_idx_ff   <= res_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      cmp_zero_ff  <= cmp_zero_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // Sample and max walks only read the table.
   `DDS_ASSERT(a_search_read_only, clock, reset,
      (state_ff == ST_WALK && !cfg_walk_ff && (cmd_ff == CMD_SAMPLE || cmd_ff == CMD_MAX))
      |-> !mem_we, "table written during a search walk")
   // A sampled index always lies inside the distribution.
   `DDS_ASSERT(a_sample_in_size, clock, reset,
      (rsp_load && cmd_ff == CMD_SAMPLE) |-> (CNT_W'(res_idx_ff) < size_ff),
      "sampled index beyond size in use")
   // A response appears only out of the finish state.
   `DDS_ASSERT(a_rsp_from_finish, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH),
      "response raised outside finish")
   // Reset always restarts the clearing pass with no response pending.
   `DDS_ASSERT_ANY(a_reset_clears, clock,
      reset |=> (state_ff == ST_CLEAR && !rsp_valid_ff && iss_ff == '0),
      "reset did not restart clearing")

endmodule
